// ===== design/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg
// Shared widths, operation codes and types of the tour move engine.
// ----------------------------------------------------------------------------
package tme_pkg;

    localparam int TOUR_SLOTS = 256;
    localparam int NODE_BITS  = 8;
    localparam int IDX_W      = $clog2(TOUR_SLOTS);

    localparam int OP_W       = 3;
    localparam int POS_W      = 8;
    localparam int NODE_IO_W  = 8;
    localparam int GAIN_W     = 32;
    localparam int LEN_W      = 32;

    localparam int S_TDATA_W  = 3 * POS_W + GAIN_W + LEN_W;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_FIELDS_W = NODE_IO_W + LEN_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [LEN_W-1:0]     len_t;

    localparam op_t OP_WRITE = 3'd0;
    localparam op_t OP_READ  = 3'd1;
    localparam op_t OP_SETLN = 3'd2;
    localparam op_t OP_EXCH  = 3'd3;
    localparam op_t OP_INS   = 3'd4;
    localparam op_t OP_INV   = 3'd5;

    function automatic logic pos_ok(input logic [POS_W-1:0] pos);
        return 32'(pos) < 32'(TOUR_SLOTS);
    endfunction

endpackage

// ===== design/tour_move_engine_core.sv =====
// ----------------------------------------------------------------------------
// tour_move_engine_core
// Tour store in one synchronous RAM with slot access, length load and
// exchange, insertion and inversion moves; running length with saturation.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (lsb up)                                  | tuser
//  s_      | in  | pos_first, pos_second, node_value, gain, len_val | op
//  m_      | out | read_node, total_len, length_clamped, pad        | -
//
//  One item at a time through a single-port-read, single-port-write RAM.
//  Write, read, set length, unused op and null move go straight to the result.
//  Exchange reads both slots, then writes both; inversion swaps pairs from the ends
//  inward and insertion shifts slot by slot, each with one RAM read per slot.
//  Reset clears control and the length; tour contents are undefined.
//  A stalled result waits in the output register; the next word is taken.
// ----------------------------------------------------------------------------
module tour_move_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_first, pos_second, node_value, gain, length_value
    input  logic [tme_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [tme_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_node, total_len, length_clamped, zero pad
    output logic [tme_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_INS1  = 4'd4;
    localparam logic [3:0] S_INSW  = 4'd5;
    localparam logic [3:0] S_INSL  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    localparam int PW = tme_pkg::POS_W;
    localparam int GW = tme_pkg::GAIN_W;
    localparam int LW = tme_pkg::LEN_W;

    logic [PW-1:0]      in_pos1, in_pos2, in_node;
    logic [GW-1:0]      in_gain;
    tme_pkg::len_t      in_len;

    tme_pkg::node_t     tour_mem [tme_pkg::TOUR_SLOTS];
    tme_pkg::node_t     rdata_reg;
    logic               mem_re, mem_we;
    tme_pkg::idx_t      mem_raddr, mem_waddr;
    tme_pkg::node_t     mem_wdata;

    logic [3:0]         state_reg, state_next;
    tme_pkg::op_t       op_reg, op_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [GW-1:0]      gain_reg, gain_next;
    tme_pkg::len_t      lenval_reg, lenval_next;
    tme_pkg::idx_t      lo_reg, lo_next, hi_reg, hi_next;
    tme_pkg::idx_t      prv_lo_reg, prv_lo_next, prv_hi_reg, prv_hi_next;
    tme_pkg::node_t     tmp_reg, tmp_next;
    logic               pend_reg, pend_next;
    logic               up_reg, up_next;
    tme_pkg::len_t      length_reg, length_next;

    logic               m_valid_reg, m_valid_next;
    logic [tme_pkg::NODE_IO_W-1:0] m_node_reg, m_node_next;
    tme_pkg::len_t      m_len_reg, m_len_next;
    logic               m_clamp_reg, m_clamp_next;

    logic               p1_ok, move_ok, is_move;
    tme_pkg::idx_t      idx1, idx2, ins_nxt;
    logic [LW+1:0]      sum;

    assign in_pos1 = s_tdata[PW-1:0];
    assign in_pos2 = s_tdata[2*PW-1:PW];
    assign in_node = s_tdata[3*PW-1:2*PW];
    assign in_gain = s_tdata[3*PW+GW-1:3*PW];
    assign in_len  = s_tdata[3*PW+GW+LW-1:3*PW+GW];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{tme_pkg::M_PAD_W{1'b0}}, m_clamp_reg, m_len_reg, m_node_reg};

    assign p1_ok   = tme_pkg::pos_ok(in_pos1);
    assign move_ok = p1_ok && tme_pkg::pos_ok(in_pos2) && (in_pos1 != in_pos2);
    assign idx1    = tme_pkg::IDX_W'(in_pos1);
    assign idx2    = tme_pkg::IDX_W'(in_pos2);
    assign ins_nxt = up_reg ? lo_reg + 1'b1 : lo_reg - 1'b1;
    assign is_move = (op_reg == tme_pkg::OP_EXCH) || (op_reg == tme_pkg::OP_INS) ||
                     (op_reg == tme_pkg::OP_INV);
    assign sum     = {2'b00, length_reg} + {{2{gain_reg[GW-1]}}, gain_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tour_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= tour_mem[mem_raddr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        rd_ok_next   = rd_ok_reg;
        gain_next    = gain_reg;
        lenval_next  = lenval_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        prv_lo_next  = prv_lo_reg;
        prv_hi_next  = prv_hi_reg;
        tmp_next     = tmp_reg;
        pend_next    = pend_reg;
        up_next      = up_reg;
        length_next  = length_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_node_next  = m_node_reg;
        m_len_next   = m_len_reg;
        m_clamp_next = m_clamp_reg;
        mem_re       = 1'b0;
        mem_raddr    = lo_reg;
        mem_we       = 1'b0;
        mem_waddr    = lo_reg;
        mem_wdata    = rdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    rd_ok_next  = p1_ok;
                    gain_next   = in_gain;
                    lenval_next = in_len;
                    pend_next   = 1'b0;
                    state_next  = S_FIN;
                    unique case (s_tuser)
                        tme_pkg::OP_WRITE: begin
                            mem_we    = p1_ok;
                            mem_waddr = idx1;
                            mem_wdata = tme_pkg::NODE_BITS'(in_node);
                        end
                        tme_pkg::OP_READ: begin
                            mem_re    = p1_ok;
                            mem_raddr = idx1;
                        end
                        tme_pkg::OP_EXCH, tme_pkg::OP_INV: begin
                            if (move_ok) begin
                                lo_next    = (idx1 < idx2) ? idx1 : idx2;
                                hi_next    = (idx1 < idx2) ? idx2 : idx1;
                                state_next = S_RDA;
                            end
                        end
                        tme_pkg::OP_INS: begin
                            if (move_ok) begin
                                lo_next    = idx1;
                                hi_next    = idx2;
                                up_next    = idx1 < idx2;
                                mem_re     = 1'b1;
                                mem_raddr  = idx1;
                                state_next = S_INS1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDA: begin
                // data of the previous pair's high slot lands in its low slot
                mem_we    = pend_reg;
                mem_waddr = prv_lo_reg;
                mem_wdata = rdata_reg;
                if (lo_reg < hi_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = lo_reg;
                    state_next = S_RDB;
                end else if (pend_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_RDB: begin
                mem_re      = 1'b1;
                mem_raddr   = hi_reg;
                mem_we      = pend_reg;
                mem_waddr   = prv_hi_reg;
                mem_wdata   = tmp_reg;
                tmp_next    = rdata_reg;
                prv_lo_next = lo_reg;
                prv_hi_next = hi_reg;
                pend_next   = 1'b1;
                if (op_reg == tme_pkg::OP_EXCH) begin
                    lo_next = hi_reg;
                end else begin
                    lo_next = lo_reg + 1'b1;
                    hi_next = hi_reg - 1'b1;
                end
                state_next  = S_RDA;
            end
            S_DRAIN: begin
                mem_we     = 1'b1;
                mem_waddr  = prv_hi_reg;
                mem_wdata  = tmp_reg;
                pend_next  = 1'b0;
                state_next = S_FIN;
            end
            S_INS1: begin
                tmp_next   = rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = ins_nxt;
                state_next = S_INSW;
            end
            S_INSW: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = rdata_reg;
                lo_next   = ins_nxt;
                if (ins_nxt == hi_reg) begin
                    state_next = S_INSL;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = up_reg ? ins_nxt + 1'b1 : ins_nxt - 1'b1;
                end
            end
            S_INSL: begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = tmp_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_clamp_next = 1'b0;
                    m_node_next  = '0;
                    if (op_reg == tme_pkg::OP_READ && rd_ok_reg) begin
                        m_node_next = tme_pkg::NODE_IO_W'(rdata_reg);
                    end
                    if (op_reg == tme_pkg::OP_SETLN) begin
                        length_next = lenval_reg;
                    end else if (is_move) begin
                        if (sum[LW+1]) begin
                            length_next  = '0;
                            m_clamp_next = 1'b1;
                        end else if (sum[LW]) begin
                            length_next  = '1;
                            m_clamp_next = 1'b1;
                        end else begin
                            length_next  = sum[LW-1:0];
                        end
                    end
                    m_len_next = length_next;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        rd_ok_reg   <= rd_ok_next;
        gain_reg    <= gain_next;
        lenval_reg  <= lenval_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        prv_lo_reg  <= prv_lo_next;
        prv_hi_reg  <= prv_hi_next;
        tmp_reg     <= tmp_next;
        up_reg      <= up_next;
        m_node_reg  <= m_node_next;
        m_len_reg   <= m_len_next;
        m_clamp_reg <= m_clamp_next;
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start processing");

    a_clamp_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_clamp_reg) |-> (m_len_reg == '0 || m_len_reg == '1))
        else $error("clamped length not at a bound");

    a_no_pending_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("swap write left pending at idle");

    a_ins_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSW) |-> (lo_reg != hi_reg))
        else $error("insertion walk overran its target slot");

endmodule

// ===== tb/tb_tour_move_engine_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tour_move_engine_core
// Self-checking bench for the tour move engine. The whole tour is loaded
// first, then a short table of corner words is run, then random traffic that
// is mostly short moves with a few that span the tour. A behavioural copy of
// the tour and the length predicts results the table does not fix; both stream
// sides idle at random, with one long back-pressure hold and one full drain.
// ----------------------------------------------------------------------------
module tb_tour_move_engine_core;

    localparam tme_pkg::op_t OP_SPARE6 = 3'd6;
    localparam tme_pkg::op_t OP_SPARE7 = 3'd7;
    localparam int  RAND_WORDS = 320;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES = 300;

    typedef struct packed {
        tme_pkg::node_t node;
        tme_pkg::len_t  len;
        logic           clamp;
    } move_result_t;

    typedef struct packed {
        tme_pkg::op_t  op;
        logic [7:0]    p1;
        logic [7:0]    p2;
        logic [7:0]    node;
        logic [31:0]   gain;
        tme_pkg::len_t lenv;
        logic          typed;
        move_result_t  want;
    } probe_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [tme_pkg::S_TDATA_W-1:0] s_tdata;
    logic [tme_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [tme_pkg::M_TDATA_W-1:0] m_tdata;

    tme_pkg::node_t tour_copy [tme_pkg::TOUR_SLOTS];
    tme_pkg::len_t  length_copy;
    move_result_t   pending_results [$];

    int  errors;
    int  words_sent;
    int  moves_sent;
    int  clamps_seen;
    int  reads_sent;
    int  results_seen;
    bit  steady;
    bit  hold_req;

    // corner words; length is zero once the tour is loaded
    probe_row_t probe_table [25] = '{
        '{OP_SPARE6, 8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{8'h00, 32'h0000_0000, 1'b0}},
        '{OP_SPARE7, 8'hFF,  8'hFF,  8'hFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{8'h00, 32'h0000_0000, 1'b0}},
        '{tme_pkg::OP_EXCH,  8'd0,   8'd255, 8'd0,   32'hFFFF_FFFF, 32'd0,         1'b1,
          '{8'h00, 32'h0000_0000, 1'b1}},
        '{tme_pkg::OP_SETLN, 8'd0,   8'd0,   8'd0,   32'd0,         32'hFFFF_FFFF, 1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_INS,   8'd0,   8'd255, 8'd0,   32'd1,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b1}},
        '{tme_pkg::OP_INS,   8'd255, 8'd0,   8'd0,   32'h7FFF_FFFF, 32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b1}},
        '{tme_pkg::OP_SETLN, 8'd0,   8'd0,   8'd0,   32'd0,         32'h8000_0000, 1'b1,
          '{8'h00, 32'h8000_0000, 1'b0}},
        '{tme_pkg::OP_INV,   8'd0,   8'd255, 8'd0,   32'h8000_0000, 32'd0,         1'b1,
          '{8'h00, 32'h0000_0000, 1'b0}},
        '{tme_pkg::OP_INV,   8'd255, 8'd0,   8'd0,   32'h8000_0000, 32'd0,         1'b1,
          '{8'h00, 32'h0000_0000, 1'b1}},
        '{tme_pkg::OP_SETLN, 8'd0,   8'd0,   8'd0,   32'd0,         32'h7FFF_FFFF, 1'b1,
          '{8'h00, 32'h7FFF_FFFF, 1'b0}},
        '{tme_pkg::OP_EXCH,  8'd17,  8'd17,  8'd0,   32'h7FFF_FFFF, 32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFE, 1'b0}},
        '{tme_pkg::OP_INS,   8'd40,  8'd40,  8'd0,   32'd1,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_INV,   8'd99,  8'd99,  8'd0,   32'd1,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b1}},
        '{tme_pkg::OP_WRITE, 8'd0,   8'd0,   8'hFF,  32'd0,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_WRITE, 8'd255, 8'd0,   8'h00,  32'd0,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_READ,  8'd0,   8'd0,   8'd0,   32'd0,         32'd0,         1'b1,
          '{8'hFF, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_READ,  8'd255, 8'd0,   8'd0,   32'd0,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_EXCH,  8'd0,   8'd255, 8'd0,   32'd0,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_READ,  8'd0,   8'd0,   8'd0,   32'd0,         32'd0,         1'b1,
          '{8'h00, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_READ,  8'd255, 8'd0,   8'd0,   32'd0,         32'd0,         1'b1,
          '{8'hFF, 32'hFFFF_FFFF, 1'b0}},
        '{tme_pkg::OP_SETLN, 8'd0,   8'd0,   8'd0,   32'd0,         32'd1000,      1'b1,
          '{8'h00, 32'd1000, 1'b0}},
        '{tme_pkg::OP_INS,   8'd3,   8'd200, 8'd0,   32'hFFFF_FFF6, 32'd0,      1'b0, '0},
        '{tme_pkg::OP_INV,   8'd200, 8'd3,   8'd0,   32'd5,         32'd0,      1'b0, '0},
        '{tme_pkg::OP_READ,  8'd100, 8'd0,   8'd0,   32'd0,         32'd0,      1'b0, '0},
        '{tme_pkg::OP_READ,  8'd3,   8'd0,   8'd0,   32'd0,         32'd0,      1'b0, '0}
    };

    tour_move_engine_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic move_result_t predict_tour_word(input tme_pkg::op_t op,
                                                       input logic [7:0] p1,
                                                       input logic [7:0] p2,
                                                       input logic [7:0] node,
                                                       input logic [31:0] gain,
                                                       input tme_pkg::len_t lenv);
        move_result_t   r;
        longint         sum;
        int             a;
        int             b;
        int             lo;
        int             hi;
        int             i;
        tme_pkg::node_t held;
        r = '0;
        a = int'(p1);
        b = int'(p2);
        case (op)
            tme_pkg::OP_WRITE: begin
                if (a < tme_pkg::TOUR_SLOTS) tour_copy[a] = node[tme_pkg::NODE_BITS-1:0];
            end
            tme_pkg::OP_READ: begin
                if (a < tme_pkg::TOUR_SLOTS) r.node = tour_copy[a];
            end
            tme_pkg::OP_SETLN: begin
                length_copy = lenv;
            end
            tme_pkg::OP_EXCH, tme_pkg::OP_INS, tme_pkg::OP_INV: begin
                if (a != b && a < tme_pkg::TOUR_SLOTS && b < tme_pkg::TOUR_SLOTS) begin
                    if (op == tme_pkg::OP_EXCH) begin
                        held = tour_copy[a];
                        tour_copy[a] = tour_copy[b];
                        tour_copy[b] = held;
                    end else if (op == tme_pkg::OP_INS) begin
                        held = tour_copy[a];
                        if (a < b) begin
                            for (i = a; i < b; i++) tour_copy[i] = tour_copy[i+1];
                        end else begin
                            for (i = a; i > b; i--) tour_copy[i] = tour_copy[i-1];
                        end
                        tour_copy[b] = held;
                    end else begin
                        lo = (a < b) ? a : b;
                        hi = (a < b) ? b : a;
                        while (lo < hi) begin
                            held = tour_copy[lo];
                            tour_copy[lo] = tour_copy[hi];
                            tour_copy[hi] = held;
                            lo++;
                            hi--;
                        end
                    end
                end
                sum = longint'(length_copy) + longint'($signed(gain));
                if (sum < 0) begin
                    length_copy = '0;
                    r.clamp = 1'b1;
                end else if (sum > 64'sh0000_0000_FFFF_FFFF) begin
                    length_copy = '1;
                    r.clamp = 1'b1;
                end else begin
                    length_copy = sum[31:0];
                end
            end
            default: ;
        endcase
        r.len = length_copy;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
        errors++;
    endtask

    task automatic send_word(input tme_pkg::op_t op, input logic [7:0] p1,
                             input logic [7:0] p2, input logic [7:0] node,
                             input logic [31:0] gain, input tme_pkg::len_t lenv,
                             input logic typed, input move_result_t want);
        move_result_t pred;
        int           gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {lenv, gain, node, p2, p1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_tour_word(op, p1, p2, node, gain, lenv);
        pending_results.push_back(typed ? want : pred);
        words_sent++;
        if (op == tme_pkg::OP_EXCH || op == tme_pkg::OP_INS || op == tme_pkg::OP_INV)
            moves_sent++;
        if (op == tme_pkg::OP_READ) reads_sent++;
        if (pred.clamp) clamps_seen++;
        gap = idle_len();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = aresetn;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    always @(posedge aclk) begin : check_results
        move_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 64'd0, 64'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.node)
                    report_mismatch("read_node", 64'(want.node), 64'(m_tdata[7:0]));
                if (m_tdata[39:8] !== want.len)
                    report_mismatch("total_len", 64'(want.len), 64'(m_tdata[39:8]));
                if (m_tdata[40] !== want.clamp)
                    report_mismatch("length_clamped", 64'(want.clamp), 64'(m_tdata[40]));
                if (m_tdata[tme_pkg::M_TDATA_W-1:tme_pkg::M_FIELDS_W] !== '0)
                    report_mismatch("pad", 64'd0,
                                    64'(m_tdata[tme_pkg::M_TDATA_W-1:tme_pkg::M_FIELDS_W]));
            end
        end
    end

    initial begin
        int            n;
        int            r;
        int            d;
        int            a;
        int            b;
        tme_pkg::op_t  op;
        logic [31:0]   gain;
        tme_pkg::len_t lenv;
        errors       = 0;
        words_sent   = 0;
        moves_sent   = 0;
        clamps_seen  = 0;
        reads_sent   = 0;
        results_seen = 0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        length_copy  = '0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // load every slot so no move or read touches an unwritten entry
        for (n = 0; n < tme_pkg::TOUR_SLOTS; n++)
            send_word(tme_pkg::OP_WRITE, 8'(n), 8'($urandom), 8'($urandom), $urandom,
                      $urandom, 1'b0, '0);

        for (n = 0; n < 25; n++)
            send_word(probe_table[n].op, probe_table[n].p1, probe_table[n].p2,
                      probe_table[n].node, probe_table[n].gain, probe_table[n].lenv,
                      probe_table[n].typed, probe_table[n].want);

        for (n = 0; n < RAND_WORDS; n++) begin
            steady = ((n / 50) % 4 == 1) || (n >= 150 && n < 180);
            if (n == 150) hold_req = 1'b1;
            if (n == 250) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            r = $urandom_range(0, 99);
            if      (r < 12) op = tme_pkg::OP_WRITE;
            else if (r < 30) op = tme_pkg::OP_READ;
            else if (r < 36) op = tme_pkg::OP_SETLN;
            else if (r < 52) op = tme_pkg::OP_EXCH;
            else if (r < 73) op = tme_pkg::OP_INS;
            else if (r < 94) op = tme_pkg::OP_INV;
            else             op = r[0] ? OP_SPARE6 : OP_SPARE7;
            a = $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 85) begin
                d = $urandom_range(0, 8);
                if ($urandom_range(0, 1)) b = (a + d > 255) ? 255 : a + d;
                else                      b = (a < d) ? 0 : a - d;
            end else begin
                b = $urandom_range(0, 255);
            end
            if ($urandom_range(0, 9) < 7) gain = 32'($urandom_range(0, 2000)) - 32'd1000;
            else                          gain = $urandom;
            case ($urandom_range(0, 3))
                0:       lenv = $urandom_range(0, 3000);
                1:       lenv = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                default: lenv = $urandom;
            endcase
            send_word(op, 8'(a), 8'(b), 8'($urandom), gain, lenv, 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        steady = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words in, %0d results back: %0d moves, %0d reads, %0d saturated",
                 words_sent, results_seen, moves_sent, reads_sent, clamps_seen);
        $display("covered full-tour moves, null moves, spare ops, long hold and full drain");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
